>>> hdl/clt_pkg.sv
// shared types, codes and helpers for the lcd terminal cursor block
package clt_pkg;

	// character codes the front part recognizes
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	// row state is two bits, so at most four rows are tracked
	localparam logic [2:0] MAX_ROWS = 3'd4;

	// cap on commands per input item
	localparam int MAX_RES = 16;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	typedef enum logic [0:0] {
		REG_COLUMNS = 1'b0,
		REG_ROWS    = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SETCUR = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_SETPOS  = 3'd1,
		OP_NEWLINE = 3'd2,
		OP_CR      = 3'd3,
		OP_FF      = 3'd4,
		OP_TAB     = 3'd5,
		OP_BS      = 3'd6,
		OP_PRINT   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_FETCH = 3'd0,
		ST_WRAP  = 3'd1,
		ST_CLEAR = 3'd2,
		ST_HOME  = 3'd3,
		ST_POS   = 3'd4,
		ST_WRITE = 3'd5,
		ST_NONE  = 3'd6
	} state_t;

	typedef struct packed {
		logic [5:0] columns;
		logic [2:0] rows;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [5:0] col;
		logic [1:0] row;
	} op_beat_t;

	typedef struct packed {
		cmd_t       command;
		logic [5:0] cmd_col;
		logic [1:0] cmd_row;
		logic [7:0] cmd_char;
		logic [5:0] cursor_col;
		logic [1:0] cursor_row;
		logic       last;
	} res_beat_t;

	function automatic logic [2:0] eff_rows(input logic [2:0] r);
		return (r > MAX_ROWS) ? MAX_ROWS : r;
	endfunction

endpackage

>>> hdl/char_lcd_terminal_cursor.sv
// top level: character stream to lcd commands with cursor tracking
//
//  channel   handshake            beat
//  input     push / full          kind, char_code, target_col, target_row
//  result    pop / empty          command, cmd_col, cmd_row, cmd_char,
//                                 cursor_col, cursor_row, last
//  config    cfg_we               cfg_index, cfg_data
//
// one fetch step per item, then one state per command and a wrap check per glyph;
// a printed character goes through fetch, wrap check, set cursor and write, with
// clear and home added when the wrap clears; a tab repeats the last three per space;
// reset clears the cursor to 0,0 and loads 16 columns, 2 rows; no clearing pass
// a full result queue holds the sequencer in place; the operation queue lets
// the input side keep taking beats meanwhile
module char_lcd_terminal_cursor #(
	parameter int TAB_WIDTH  = 4,
	parameter int OPQ_DEPTH  = 2,
	parameter int RESQ_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] char_code,
	input  logic [5:0] target_col,
	input  logic [2:0] target_row,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] command,
	output logic [5:0] cmd_col,
	output logic [1:0] cmd_row,
	output logic [7:0] cmd_char,
	output logic [5:0] cursor_col,
	output logic [1:0] cursor_row,
	output logic       last,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int OPW  = $bits(clt_pkg::op_beat_t);
	localparam int RESW = $bits(clt_pkg::res_beat_t);

	clt_pkg::cfg_t      cfg_q;
	clt_pkg::op_beat_t  op_in;
	clt_pkg::op_beat_t  op_out;
	clt_pkg::res_beat_t res_in;
	clt_pkg::res_beat_t res_out;
	logic [OPW-1:0]     opq_rdata;
	logic [RESW-1:0]    resq_rdata;
	logic               opq_empty;
	logic               op_pop;
	logic               res_full;
	logic               res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns <= 6'd16;
			cfg_q.rows    <= 3'd2;
		end else if (cfg_we) begin
			case (clt_pkg::reg_idx_t'(cfg_index))
				clt_pkg::REG_COLUMNS: cfg_q.columns <= cfg_data;
				clt_pkg::REG_ROWS:    cfg_q.rows    <= cfg_data[2:0];
				default:              cfg_q         <= cfg_q;
			endcase
		end
	end

	clt_front u_front (
		.kind       (kind),
		.char_code  (char_code),
		.target_col (target_col),
		.target_row (target_row),
		.cfg        (cfg_q),
		.op         (op_in)
	);

	clt_fifo #(
		.WIDTH (OPW),
		.DEPTH (OPQ_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (op_in),
		.full   (full),
		.pop    (op_pop),
		.rdata  (opq_rdata),
		.empty  (opq_empty)
	);

	assign op_out = clt_pkg::op_beat_t'(opq_rdata);

	clt_back #(
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_valid (!opq_empty),
		.op       (op_out),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	clt_fifo #(
		.WIDTH (RESW),
		.DEPTH (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (resq_rdata),
		.empty  (empty)
	);

	assign res_out    = clt_pkg::res_beat_t'(resq_rdata);
	assign command    = res_out.command;
	assign cmd_col    = res_out.cmd_col;
	assign cmd_row    = res_out.cmd_row;
	assign cmd_char   = res_out.cmd_char;
	assign cursor_col = res_out.cursor_col;
	assign cursor_row = res_out.cursor_row;
	assign last       = res_out.last;

endmodule

>>> hdl/clt_fifo.sv
// small register queue used between the parts of the block
module clt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/clt_front.sv
// front part: classifies an input beat into a cursor operation
module clt_front (
	input  logic              kind,
	input  logic [7:0]        char_code,
	input  logic [5:0]        target_col,
	input  logic [2:0]        target_row,
	input  clt_pkg::cfg_t     cfg,
	output clt_pkg::op_beat_t op
);

	logic in_range;

	assign in_range = (target_col < cfg.columns) &&
		(target_row < clt_pkg::eff_rows(cfg.rows));

	always_comb begin
		op.ch  = char_code;
		op.col = target_col;
		op.row = target_row[1:0];
		if (kind) begin
			op.op = in_range ? clt_pkg::OP_SETPOS : clt_pkg::OP_NONE;
		end else begin
			case (char_code)
				clt_pkg::CH_LF: op.op = clt_pkg::OP_NEWLINE;
				clt_pkg::CH_CR: op.op = clt_pkg::OP_CR;
				clt_pkg::CH_FF: op.op = clt_pkg::OP_FF;
				clt_pkg::CH_TAB: begin
					op.op = clt_pkg::OP_TAB;
					op.ch = clt_pkg::CH_SPACE;
				end
				clt_pkg::CH_BS: begin
					op.op = clt_pkg::OP_BS;
					op.ch = clt_pkg::CH_SPACE;
				end
				default: begin
					if (char_code inside {[clt_pkg::PRINT_LO:clt_pkg::PRINT_HI]}) begin
						op.op = clt_pkg::OP_PRINT;
					end else begin
						op.op = clt_pkg::OP_NONE;
					end
				end
			endcase
		end
	end

endmodule

>>> hdl/clt_back.sv
// back part: cursor state and the command sequencer
module clt_back #(
	parameter int TAB_WIDTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clt_pkg::cfg_t      cfg,
	input  logic               op_valid,
	input  clt_pkg::op_beat_t  op,
	output logic               op_pop,
	input  logic               res_full,
	output logic               res_push,
	output clt_pkg::res_beat_t res
);

	localparam int NW = $clog2(TAB_WIDTH + 1);
	localparam int CW = clt_pkg::CNT_W;

	clt_pkg::state_t state_q, state_d;
	clt_pkg::op_t    op_q;
	logic [7:0]      ch_q;
	logic [NW-1:0]   left_q;
	logic            bs_phase_q;
	logic [CW-1:0]   cnt_q;
	logic [5:0]      col_q;
	logic [1:0]      row_q;

	logic emit;
	logic final_cmd;
	logic capped;
	logic go;
	logic row_adv;
	logic wrap_need;

	// spaces from a column to the next tab stop
	function automatic logic [NW-1:0] tab_span(input logic [5:0] c);
		logic [NW-1:0] r;
		r = '0;
		for (int k = 0; k < 64; k++) begin
			if (c == 6'(k)) begin
				r = NW'(TAB_WIDTH - (k % TAB_WIDTH));
			end
		end
		return r;
	endfunction

	assign row_adv   = ({1'b0, row_q} + 3'd1) < clt_pkg::eff_rows(cfg.rows);
	assign wrap_need = (col_q >= cfg.columns);
	assign capped    = (cnt_q >= CW'(clt_pkg::MAX_RES));
	assign go        = !emit || capped || !res_full;
	assign res_push  = emit && !capped && !res_full;
	assign op_pop    = (state_q == clt_pkg::ST_FETCH) && op_valid;

	// outputs of the sequencer
	always_comb begin
		emit           = 1'b0;
		final_cmd      = 1'b0;
		res.command    = clt_pkg::CMD_NONE;
		res.cmd_col    = '0;
		res.cmd_row    = '0;
		res.cmd_char   = '0;
		res.cursor_col = col_q;
		res.cursor_row = row_q;
		case (state_q)
			clt_pkg::ST_CLEAR: begin
				emit        = 1'b1;
				res.command = clt_pkg::CMD_CLEAR;
			end
			clt_pkg::ST_HOME: begin
				emit        = 1'b1;
				res.command = clt_pkg::CMD_SETCUR;
				final_cmd   = (op_q == clt_pkg::OP_FF);
			end
			clt_pkg::ST_POS: begin
				emit        = 1'b1;
				res.command = clt_pkg::CMD_SETCUR;
				res.cmd_col = col_q;
				res.cmd_row = row_q;
				final_cmd   = (op_q == clt_pkg::OP_NEWLINE) || (op_q == clt_pkg::OP_CR) ||
					(op_q == clt_pkg::OP_SETPOS) || ((op_q == clt_pkg::OP_BS) && bs_phase_q);
			end
			clt_pkg::ST_WRITE: begin
				emit         = 1'b1;
				res.command  = clt_pkg::CMD_WRITE;
				res.cmd_char = ch_q;
				final_cmd    = (op_q == clt_pkg::OP_PRINT) ||
					((op_q == clt_pkg::OP_TAB) && (left_q == NW'(1)));
			end
			clt_pkg::ST_NONE: begin
				emit      = 1'b1;
				final_cmd = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		// past the cap the last kept command closes the item
		res.last = final_cmd || (cnt_q == CW'(clt_pkg::MAX_RES - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			clt_pkg::ST_FETCH: begin
				if (op_valid) begin
					case (op.op)
						clt_pkg::OP_SETPOS:  state_d = clt_pkg::ST_POS;
						clt_pkg::OP_CR:      state_d = clt_pkg::ST_POS;
						clt_pkg::OP_NEWLINE: state_d = row_adv ? clt_pkg::ST_POS : clt_pkg::ST_CLEAR;
						clt_pkg::OP_FF:      state_d = clt_pkg::ST_CLEAR;
						clt_pkg::OP_TAB:     state_d = clt_pkg::ST_WRAP;
						clt_pkg::OP_PRINT:   state_d = clt_pkg::ST_WRAP;
						clt_pkg::OP_BS:      state_d = (col_q != '0) ? clt_pkg::ST_POS : clt_pkg::ST_NONE;
						default:             state_d = clt_pkg::ST_NONE;
					endcase
				end
			end
			clt_pkg::ST_WRAP: begin
				state_d = (wrap_need && !row_adv) ? clt_pkg::ST_CLEAR : clt_pkg::ST_POS;
			end
			clt_pkg::ST_CLEAR: begin
				if (go) begin
					state_d = clt_pkg::ST_HOME;
				end
			end
			clt_pkg::ST_HOME: begin
				if (go) begin
					state_d = final_cmd ? clt_pkg::ST_FETCH : clt_pkg::ST_POS;
				end
			end
			clt_pkg::ST_POS: begin
				if (go) begin
					state_d = final_cmd ? clt_pkg::ST_FETCH : clt_pkg::ST_WRITE;
				end
			end
			clt_pkg::ST_WRITE: begin
				if (go) begin
					if (final_cmd) begin
						state_d = clt_pkg::ST_FETCH;
					end else if (op_q == clt_pkg::OP_BS) begin
						state_d = clt_pkg::ST_POS;
					end else begin
						state_d = clt_pkg::ST_WRAP;
					end
				end
			end
			clt_pkg::ST_NONE: begin
				if (go) begin
					state_d = clt_pkg::ST_FETCH;
				end
			end
			default: state_d = clt_pkg::ST_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= clt_pkg::ST_FETCH;
			op_q       <= clt_pkg::OP_NONE;
			ch_q       <= '0;
			left_q     <= '0;
			bs_phase_q <= 1'b0;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			state_q <= state_d;
			if (res_push) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				clt_pkg::ST_FETCH: begin
					if (op_valid) begin
						op_q       <= op.op;
						ch_q       <= op.ch;
						left_q     <= tab_span(col_q);
						bs_phase_q <= 1'b0;
						cnt_q      <= '0;
						case (op.op)
							clt_pkg::OP_SETPOS: begin
								col_q <= op.col;
								row_q <= op.row;
							end
							clt_pkg::OP_NEWLINE: begin
								col_q <= '0;
								row_q <= row_adv ? row_q + 2'd1 : 2'd0;
							end
							clt_pkg::OP_CR: col_q <= '0;
							clt_pkg::OP_FF: begin
								col_q <= '0;
								row_q <= '0;
							end
							clt_pkg::OP_BS: begin
								if (col_q != '0) begin
									col_q <= col_q - 6'd1;
								end
							end
							default: begin
								col_q <= col_q;
							end
						endcase
					end
				end
				clt_pkg::ST_WRAP: begin
					// deferred wrap happens only when the next character prints
					if (wrap_need) begin
						col_q <= '0;
						row_q <= row_adv ? row_q + 2'd1 : 2'd0;
					end
				end
				clt_pkg::ST_POS: begin
					if (go) begin
						if (op_q == clt_pkg::OP_BS) begin
							bs_phase_q <= 1'b1;
						end else if ((op_q == clt_pkg::OP_PRINT) || (op_q == clt_pkg::OP_TAB)) begin
							col_q <= col_q + 6'd1;
						end
					end
				end
				clt_pkg::ST_WRITE: begin
					if (go && !final_cmd && (op_q == clt_pkg::OP_TAB)) begin
						left_q <= left_q - NW'(1);
					end
				end
				default: begin
					col_q <= col_q;
				end
			endcase
		end
	end

endmodule

>>> dv/char_lcd_terminal_cursor_chk.sv
// checker: tracks the cursor from accepted beats and compares every result beat
module char_lcd_terminal_cursor_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic       kind,
	input  logic [7:0] char_code,
	input  logic [5:0] target_col,
	input  logic [2:0] target_row,
	input  logic       empty,
	input  logic       pop,
	input  logic [1:0] command,
	input  logic [5:0] cmd_col,
	input  logic [1:0] cmd_row,
	input  logic [7:0] cmd_char,
	input  logic [5:0] cursor_col,
	input  logic [1:0] cursor_row,
	input  logic       last,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [5:0] cfg_data,
	output int         errors,
	output int         pending
);

	localparam int TAB_W = 4;

	logic [5:0] geo_cols;
	logic [2:0] geo_rows;
	logic [5:0] cur_col;
	logic [1:0] cur_row;

	clt_pkg::res_beat_t item_cmds [clt_pkg::MAX_RES];
	int                 item_cnt;
	clt_pkg::res_beat_t cmds_due [$];
	clt_pkg::res_beat_t want_cmd;

	// the row counter is two bits, so anything above four rows acts as four
	function automatic logic [2:0] rows_in_use();
		return (geo_rows > clt_pkg::MAX_ROWS) ? clt_pkg::MAX_ROWS : geo_rows;
	endfunction

	task automatic add_cmd(input clt_pkg::cmd_t c, input logic [5:0] col,
			input logic [1:0] row, input logic [7:0] ch);
		clt_pkg::res_beat_t b;
		if (item_cnt < clt_pkg::MAX_RES) begin
			b.command    = c;
			b.cmd_col    = col;
			b.cmd_row    = row;
			b.cmd_char   = ch;
			b.cursor_col = cur_col;
			b.cursor_row = cur_row;
			b.last       = 1'b0;
			item_cmds[item_cnt] = b;
			item_cnt++;
		end
	endtask

	task automatic clear_and_home();
		cur_col = '0;
		cur_row = '0;
		add_cmd(clt_pkg::CMD_CLEAR, 6'd0, 2'd0, 8'd0);
		add_cmd(clt_pkg::CMD_SETCUR, 6'd0, 2'd0, 8'd0);
	endtask

	task automatic new_line();
		cur_col = '0;
		if (int'(cur_row) + 1 < int'(rows_in_use()))
			cur_row = cur_row + 2'd1;
		else
			clear_and_home();
	endtask

	// deferred wrap: the column may sit at geo_cols until the next glyph
	task automatic print_glyph(input logic [7:0] ch);
		if (cur_col >= geo_cols)
			new_line();
		add_cmd(clt_pkg::CMD_SETCUR, cur_col, cur_row, 8'd0);
		cur_col = cur_col + 6'd1;
		add_cmd(clt_pkg::CMD_WRITE, 6'd0, 2'd0, ch);
	endtask

	task automatic issue_commands(input logic k, input logic [7:0] ch, input logic [5:0] tc,
			input logic [2:0] tr);
		int pad;
		item_cnt = 0;
		if (k) begin
			if (tc < geo_cols && tr < rows_in_use()) begin
				cur_col = tc;
				cur_row = tr[1:0];
				add_cmd(clt_pkg::CMD_SETCUR, cur_col, cur_row, 8'd0);
			end
		end else begin
			case (ch)
				clt_pkg::CH_LF: begin
					new_line();
					add_cmd(clt_pkg::CMD_SETCUR, cur_col, cur_row, 8'd0);
				end
				clt_pkg::CH_CR: begin
					cur_col = '0;
					add_cmd(clt_pkg::CMD_SETCUR, 6'd0, cur_row, 8'd0);
				end
				clt_pkg::CH_FF: clear_and_home();
				clt_pkg::CH_TAB: begin
					pad = TAB_W - (int'(cur_col) % TAB_W);
					for (int i = 0; i < pad; i++)
						print_glyph(clt_pkg::CH_SPACE);
				end
				clt_pkg::CH_BS: begin
					if (cur_col > 6'd0) begin
						cur_col = cur_col - 6'd1;
						add_cmd(clt_pkg::CMD_SETCUR, cur_col, cur_row, 8'd0);
						add_cmd(clt_pkg::CMD_WRITE, 6'd0, 2'd0, clt_pkg::CH_SPACE);
						add_cmd(clt_pkg::CMD_SETCUR, cur_col, cur_row, 8'd0);
					end
				end
				default: begin
					if (ch >= clt_pkg::PRINT_LO && ch <= clt_pkg::PRINT_HI)
						print_glyph(ch);
				end
			endcase
		end
		if (item_cnt == 0)
			add_cmd(clt_pkg::CMD_NONE, 6'd0, 2'd0, 8'd0);
		item_cmds[item_cnt - 1].last = 1'b1;
		for (int i = 0; i < item_cnt; i++)
			cmds_due.push_back(item_cmds[i]);
	endtask

	task automatic check_field(input string nm, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, nm, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_cols = 6'd16;
			geo_rows = 3'd2;
			cur_col  = '0;
			cur_row  = '0;
			errors   = 0;
			cmds_due.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (cmds_due.size() == 0) begin
					errors++;
					$display("%0t: result beat expected none, got command %0d", $time,
						command);
				end else begin
					want_cmd = cmds_due.pop_front();
					check_field("command", want_cmd.command, command);
					check_field("cmd_col", want_cmd.cmd_col, cmd_col);
					check_field("cmd_row", want_cmd.cmd_row, cmd_row);
					check_field("cmd_char", want_cmd.cmd_char, cmd_char);
					check_field("cursor_col", want_cmd.cursor_col, cursor_col);
					check_field("cursor_row", want_cmd.cursor_row, cursor_row);
					check_field("last", want_cmd.last, last);
				end
			end
			if (cfg_we) begin
				case (clt_pkg::reg_idx_t'(cfg_index))
					clt_pkg::REG_COLUMNS: geo_cols = cfg_data;
					clt_pkg::REG_ROWS:    geo_rows = cfg_data[2:0];
					default: ;
				endcase
			end
			if (push && !full)
				issue_commands(kind, char_code, target_col, target_row);
			pending <= cmds_due.size();
		end
	end

endmodule

>>> dv/char_lcd_terminal_cursor_tb.sv
// testbench top: clock, reset, stimulus and verdict for the lcd terminal cursor
module char_lcd_terminal_cursor_tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 43;
	localparam int NUM_PHASES  = 8;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       push       = 1'b0;
	logic       kind       = 1'b0;
	logic [7:0] char_code  = '0;
	logic [5:0] target_col = '0;
	logic [2:0] target_row = '0;
	logic       pop        = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [0:0] cfg_index  = '0;
	logic [5:0] cfg_data   = '0;
	logic       full;
	logic       empty;
	logic [1:0] command;
	logic [5:0] cmd_col;
	logic [1:0] cmd_row;
	logic [7:0] cmd_char;
	logic [5:0] cursor_col;
	logic [1:0] cursor_row;
	logic       last;

	int errors;
	int pending;
	int send_idle    = 0;
	int recv_stall   = 0;
	int quiet_cycles = 0;
	bit hold_go      = 1'b0;

	// geometry per phase: extremes, zero sizes and oversize values included
	int ph_cols [NUM_PHASES] = '{1, 40, 0, 63, 5, 16, 8, 40};
	int ph_rows [NUM_PHASES] = '{1, 4, 0, 7, 3, 2, 4, 1};

	char_lcd_terminal_cursor dut (.*);

	char_lcd_terminal_cursor_chk chk (.*);

	always #4 clk = ~clk;

	task automatic send_beat(input logic k, input logic [7:0] ch, input logic [5:0] tc,
			input logic [2:0] tr);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		kind       <= k;
		char_code  <= ch;
		target_col <= tc;
		target_row <= tr;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_beat(1'b0, ch, 6'($urandom_range(63)), 3'($urandom_range(7)));
	endtask

	task automatic set_cursor(input logic [5:0] col, input logic [2:0] row);
		send_beat(1'b1, 8'($urandom_range(255)), col, row);
	endtask

	task automatic rand_beat(input logic [5:0] c, input logic [2:0] r);
		int         pick;
		logic [2:0] er;
		logic       k;
		logic [7:0] ch;
		logic [5:0] tc;
		logic [2:0] tr;
		pick = $urandom_range(99);
		er   = (r > 3'd4) ? 3'd4 : r;
		k    = 1'b0;
		ch   = 8'($urandom_range(255));
		tc   = 6'($urandom_range(63));
		tr   = 3'($urandom_range(7));
		if (pick < 52) begin
			ch = 8'($urandom_range(126, 32));
		end else if (pick < 74) begin
			case ($urandom_range(4))
				0:       ch = clt_pkg::CH_LF;
				1:       ch = clt_pkg::CH_CR;
				2:       ch = clt_pkg::CH_FF;
				3:       ch = clt_pkg::CH_TAB;
				default: ch = clt_pkg::CH_BS;
			endcase
		end else if (pick < 88) begin
			k = 1'b1;
			// mostly legal targets so the cursor really moves
			if (c != 6'd0 && er != 3'd0 && $urandom_range(3) != 0) begin
				tc = 6'($urandom_range(int'(c) - 1));
				tr = 3'($urandom_range(int'(er) - 1));
			end
		end
		send_beat(k, ch, tc, tr);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [5:0] c, input logic [2:0] r);
		cfg_we    <= 1'b1;
		cfg_index <= clt_pkg::REG_COLUMNS;
		cfg_data  <= c;
		@(posedge clk);
		cfg_index <= clt_pkg::REG_ROWS;
		cfg_data  <= {3'b000, r};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset geometry of 16 columns, 2 rows
		put_char("A");
		put_char(clt_pkg::PRINT_HI);
		put_char(clt_pkg::PRINT_LO);
		put_char(8'd31);
		put_char(8'd127);
		send_beat(1'b0, 8'hff, 6'd63, 3'd7);
		send_beat(1'b0, 8'h00, 6'd0, 3'd0);
		put_char(clt_pkg::CH_BS);
		put_char(clt_pkg::CH_CR);
		put_char(clt_pkg::CH_BS);
		put_char(clt_pkg::CH_TAB);
		put_char(clt_pkg::CH_TAB);
		put_char(clt_pkg::CH_LF);
		set_cursor(6'd15, 3'd1);
		put_char("x");
		put_char("y");
		set_cursor(6'd16, 3'd0);
		set_cursor(6'd0, 3'd2);
		set_cursor(6'd63, 3'd7);
		put_char(clt_pkg::CH_FF);
		set_cursor(6'd14, 3'd1);
		put_char(clt_pkg::CH_TAB);
		put_char(clt_pkg::CH_TAB);
		set_cursor(6'd3, 3'd1);
		put_char(clt_pkg::CH_LF);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_geometry(6'(ph_cols[p]), 3'(ph_rows[p]));
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 46; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 46; end
				default: begin send_idle = 29; recv_stall = 29; end
			endcase
			// back up the result side while beats keep coming
			if (p == 4)
				hold_go = 1'b1;
			repeat (PHASE_ITEMS) rand_beat(6'(ph_cols[p]), 3'(ph_rows[p]));
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> char_lcd_terminal_cursor.f
hdl/clt_pkg.sv
hdl/clt_fifo.sv
hdl/clt_front.sv
hdl/clt_back.sv
hdl/char_lcd_terminal_cursor.sv
dv/char_lcd_terminal_cursor_chk.sv
dv/char_lcd_terminal_cursor_tb.sv
